### rtl/wssc_pkg.sv
// Shared types and constants for the winch soft-start controller.
package wssc_pkg;

   // Width of the saturating elapsed-time counters.
   localparam int TIME_WIDTH = 16;
   // Width of the timing and current registers.
   localparam int REG_WIDTH = 16;
   // Compare width: wide enough for both a counter and a register.
   localparam int CMP_WIDTH = (TIME_WIDTH > REG_WIDTH) ? TIME_WIDTH : REG_WIDTH;
   localparam int TORQUE_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CURRENT_WIDTH = 16;

   localparam logic [TORQUE_WIDTH-1:0] FULL_TORQUE = TORQUE_WIDTH'(1000);
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_UP   = 2'd1,
      OP_DOWN = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIR_OFF      = 2'd0,
      DIR_UP       = 2'd1,
      DIR_DOWN     = 2'd2,
      DIR_OVERLOAD = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      PH_INIT  = 2'd0,
      PH_DELAY = 2'd1,
      PH_RAMP  = 2'd2,
      PH_FULL  = 2'd3
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_TORQUE  = 3'd0,
      CSR_RAMP_STEP     = 3'd1,
      CSR_RAMP_PERIOD   = 3'd2,
      CSR_CONTACTOR_DLY = 3'd3,
      CSR_BLIND_TIME    = 3'd4,
      CSR_WINCH_LIMIT   = 3'd5,
      CSR_BOARD_LIMIT   = 3'd6,
      CSR_IDLE_TIMEOUT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [TORQUE_WIDTH-1:0] start_torque;
      logic [TORQUE_WIDTH-1:0] ramp_step;
      logic [REG_WIDTH-1:0]    ramp_period;
      logic [REG_WIDTH-1:0]    contactor_delay;
      logic [REG_WIDTH-1:0]    blind_time;
      logic [REG_WIDTH-1:0]    winch_current_limit;
      logic [REG_WIDTH-1:0]    board_current_limit;
      logic [REG_WIDTH-1:0]    idle_timeout;
   } cfg_type;

   typedef struct packed {
      op_type                   operation;
      logic                     switch_pressed;
      logic [CURRENT_WIDTH-1:0] load_current;
      logic                     winch_load_on;
      logic                     board_load_on;
   } item_type;

   typedef struct packed {
      dir_type                 direction;
      phase_type               phase;
      logic [TORQUE_WIDTH-1:0] torque;
      logic                    drive_enable;
      logic                    busy_led;
      logic                    power_cycle;
   } result_type;

endpackage

### rtl/wssc_csr.sv
// Configuration register bank of the winch soft-start controller.
module wssc_csr
   import wssc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] index,
   input  logic [CSR_DATA_WIDTH-1:0]  write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the register index and replace the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         case (csr_index_type'(index))
            CSR_START_TORQUE:  cfg_in.start_torque = write_data[TORQUE_WIDTH-1:0];
            CSR_RAMP_STEP:     cfg_in.ramp_step = write_data[TORQUE_WIDTH-1:0];
            CSR_RAMP_PERIOD:   cfg_in.ramp_period = write_data[REG_WIDTH-1:0];
            CSR_CONTACTOR_DLY: cfg_in.contactor_delay = write_data[REG_WIDTH-1:0];
            CSR_BLIND_TIME:    cfg_in.blind_time = write_data[REG_WIDTH-1:0];
            CSR_WINCH_LIMIT:   cfg_in.winch_current_limit = write_data[REG_WIDTH-1:0];
            CSR_BOARD_LIMIT:   cfg_in.board_current_limit = write_data[REG_WIDTH-1:0];
            CSR_IDLE_TIMEOUT:  cfg_in.idle_timeout = write_data[REG_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers take their documented defaults at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_torque        <= TORQUE_WIDTH'(100);
         cfg_ff.ramp_step           <= TORQUE_WIDTH'(10);
         cfg_ff.ramp_period         <= REG_WIDTH'(10);
         cfg_ff.contactor_delay     <= REG_WIDTH'(100);
         cfg_ff.blind_time          <= REG_WIDTH'(200);
         cfg_ff.winch_current_limit <= REG_WIDTH'(1000);
         cfg_ff.board_current_limit <= REG_WIDTH'(500);
         cfg_ff.idle_timeout        <= REG_WIDTH'(60000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/wssc_core.sv
// Controller state and its update for one transaction.
module wssc_core
   import wssc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   dir_type                 dir_ff, dir_in;
   phase_type               phase_ff, phase_in;
   logic [TORQUE_WIDTH-1:0] torque_ff, torque_in;
   logic                    drive_ff, drive_in;
   logic                    led_ff, led_in;
   logic [TIME_WIDTH-1:0]   since_ff, since_in;
   logic [TIME_WIDTH-1:0]   phel_ff, phel_in;
   logic [TIME_WIDTH-1:0]   idle_ff, idle_in;

   logic [TIME_WIDTH-1:0]   since_inc, phel_inc, idle_inc;
   logic [TORQUE_WIDTH-1:0] start_level;
   logic [TORQUE_WIDTH:0]   ramp_sum;
   logic                    running;
   logic                    over;
   logic                    pulse;

   // Saturating counter steps and shared terms.
   always_comb begin
      since_inc = (since_ff == TIME_MAX) ? since_ff : since_ff + 1'b1;
      phel_inc  = (phel_ff == TIME_MAX) ? phel_ff : phel_ff + 1'b1;
      idle_inc  = (idle_ff == TIME_MAX) ? idle_ff : idle_ff + 1'b1;
      start_level = (cfg.start_torque > FULL_TORQUE) ? FULL_TORQUE : cfg.start_torque;
      ramp_sum = {1'b0, torque_ff} + {1'b0, cfg.ramp_step};
      running = (dir_ff == DIR_UP) || (dir_ff == DIR_DOWN);
      over = (item.winch_load_on &&
              (item.load_current >= cfg.winch_current_limit)) ||
             (item.board_load_on &&
              (item.load_current >= cfg.board_current_limit));
   end

   // Next state for a tick or a switch change.
   always_comb begin
      dir_in    = dir_ff;
      phase_in  = phase_ff;
      torque_in = torque_ff;
      drive_in  = drive_ff;
      led_in    = led_ff;
      since_in  = since_ff;
      phel_in   = phel_ff;
      idle_in   = idle_ff;
      pulse     = 1'b0;
      case (item.operation)
         OP_TICK: begin
            since_in = since_inc;
            phel_in  = phel_inc;
            idle_in  = idle_inc;
            if (CMP_WIDTH'(idle_inc) > CMP_WIDTH'(cfg.idle_timeout)) begin
               pulse   = 1'b1;
               idle_in = '0;
            end
            // The LED follows the direction held before this tick.
            if (running) begin
               led_in = item.board_load_on;
            end else begin
               led_in = (dir_ff == DIR_OVERLOAD);
            end
            if (running) begin
               idle_in = '0;
               if (over && (CMP_WIDTH'(since_inc) >= CMP_WIDTH'(cfg.blind_time))) begin
                  dir_in   = DIR_OVERLOAD;
                  drive_in = 1'b0;
               end else begin
                  case (phase_ff)
                     PH_INIT: begin
                        phel_in  = '0;
                        since_in = '0;
                        phase_in = PH_DELAY;
                     end
                     PH_DELAY: begin
                        if (CMP_WIDTH'(phel_inc) >= CMP_WIDTH'(cfg.contactor_delay)) begin
                           torque_in = start_level;
                           phase_in  = PH_RAMP;
                           phel_in   = '0;
                           since_in  = '0;
                           drive_in  = 1'b1;
                        end
                     end
                     PH_RAMP: begin
                        if (CMP_WIDTH'(phel_inc) >= CMP_WIDTH'(cfg.ramp_period)) begin
                           phel_in = '0;
                           if (ramp_sum <= {1'b0, FULL_TORQUE}) begin
                              torque_in = ramp_sum[TORQUE_WIDTH-1:0];
                           end else begin
                              torque_in = FULL_TORQUE;
                              phase_in  = PH_FULL;
                           end
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end
         end
         OP_UP, OP_DOWN: begin
            if (item.switch_pressed) begin
               // A press only starts a run from off.
               if (dir_ff == DIR_OFF) begin
                  dir_in    = (item.operation == OP_UP) ? DIR_UP : DIR_DOWN;
                  torque_in = start_level;
                  since_in  = '0;
               end
            end else if (dir_ff != DIR_OFF) begin
               // A release stops any run or overload; torque is kept.
               dir_in   = DIR_OFF;
               drive_in = 1'b0;
               phase_in = PH_INIT;
            end
         end
         default: begin
            dir_in = dir_ff;
         end
      endcase
   end

   // State registers advance once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff    <= DIR_OFF;
         phase_ff  <= PH_INIT;
         torque_ff <= '0;
         drive_ff  <= 1'b0;
         led_ff    <= 1'b0;
         since_ff  <= '0;
         phel_ff   <= '0;
         idle_ff   <= '0;
      end else if (item_fire) begin
         dir_ff    <= dir_in;
         phase_ff  <= phase_in;
         torque_ff <= torque_in;
         drive_ff  <= drive_in;
         led_ff    <= led_in;
         since_ff  <= since_in;
         phel_ff   <= phel_in;
         idle_ff   <= idle_in;
      end
   end

   // The result shows the state after the transaction.
   always_comb begin
      result.direction    = dir_in;
      result.phase        = phase_in;
      result.torque       = torque_in;
      result.drive_enable = drive_in;
      result.busy_led     = led_in;
      result.power_cycle  = pulse;
   end

endmodule

### rtl/winch_soft_start_controller.sv
// Top level of the winch soft-start controller: channel registers and wiring.
//
// Usage: each request transaction is a tick (operation 0) or a change of the
// up or down switch (operation 1 or 2) with the switch level, motor current
// and load flags. Every request gives exactly one response transaction
// carrying direction, phase, torque, drive enable, LED level and the
// power-cycle pulse, as they stand after that request.
// Both channels use valid and stall; a transaction completes on a rising
// edge with valid high and stall low.
// A request taken at an edge is held in the request register, then processed
// by the core into the response register once that register is free.
// Throughput: one transaction per cycle while rsp_stall is low; the
// request and response registers let a new request enter while a response waits.
// When the receiver stalls, the response holds, one more request is held in
// the request register, and then req_stall rises.
// Configuration registers are written through csr_write_enable, csr_index
// and csr_write_data while no transaction is in flight.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and puts the controller off, in init, at zero torque.
module winch_soft_start_controller
   import wssc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_operation,
   input  logic                       req_switch_pressed,
   input  logic [CURRENT_WIDTH-1:0]   req_load_current,
   input  logic                       req_winch_load_on,
   input  logic                       req_board_load_on,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_direction,
   output logic [1:0]                 rsp_phase,
   output logic [TORQUE_WIDTH-1:0]    rsp_torque,
   output logic                       rsp_drive_enable,
   output logic                       rsp_busy_led,
   output logic                       rsp_power_cycle,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type    cfg;
   item_type   in_item_ff, in_item_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_res_ff, out_res_in;
   logic       out_valid_ff, out_valid_in;
   result_type core_result;
   logic       out_free;
   logic       advance;
   logic       in_open;

   wssc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   wssc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (advance),
      .item      (in_item_ff),
      .cfg       (cfg),
      .result    (core_result)
   );

   // Handshake: the request register moves on when the response register frees.
   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      advance   = in_valid_ff && out_free;
      in_open   = !in_valid_ff || advance;
      req_stall = !in_open;
   end

   // Request register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (in_open) begin
         in_valid_in              = req_valid;
         in_item_in.operation     = op_type'(req_operation);
         in_item_in.switch_pressed = req_switch_pressed;
         in_item_in.load_current  = req_load_current;
         in_item_in.winch_load_on = req_winch_load_on;
         in_item_in.board_load_on = req_board_load_on;
      end
   end

   // Response register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_free) begin
         out_valid_in = advance;
         out_res_in   = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_direction    = out_res_ff.direction;
   assign rsp_phase        = out_res_ff.phase;
   assign rsp_torque       = out_res_ff.torque;
   assign rsp_drive_enable = out_res_ff.drive_enable;
   assign rsp_busy_led     = out_res_ff.busy_led;
   assign rsp_power_cycle  = out_res_ff.power_cycle;

endmodule
